/* rtl/tlf_pkg.sv */
package tlf_pkg;

    localparam int LINE_DEPTH_DEFAULT = 64;
    localparam int ADDR_W = 6;
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] TERMINATOR_RESET = 8'd10;
    localparam logic RX_ENABLE_RESET = 1'b1;

    // Register index as decoded from paddr[2].
    localparam logic REG_TERMINATOR = 1'b0;
    localparam logic REG_RX_ENABLE = 1'b1;

    typedef struct packed {
        logic              en;
        logic              bank;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic              bank;
        logic [ADDR_W-1:0] len;
        logic              ovf;
        logic [7:0]        ovf_byte;
        logic [15:0]       number;
    } frame_desc_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

endpackage

/* rtl/tlf_front.sv */
module tlf_front #(
    parameter int LINE_DEPTH = tlf_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            terminator,
    input  logic                  rx_enable,
    input  tlf_pkg::bank_release_t release_in,
    output tlf_pkg::store_wr_t    store_wr,
    output logic                  push,
    output tlf_pkg::frame_desc_t  push_desc
);

    localparam int CAP_INT = (LINE_DEPTH - 1 > 63) ? 63 : LINE_DEPTH - 1;
    localparam logic [tlf_pkg::ADDR_W-1:0] CAPACITY = tlf_pkg::ADDR_W'(CAP_INT);

    logic [tlf_pkg::ADDR_W-1:0] pos_reg, pos_next;
    logic [15:0]                counter_reg, counter_next;
    logic                       cur_bank_reg, cur_bank_next;
    logic [1:0]                 busy_reg, busy_next;

    logic accept, live, close_term, close_ovf, do_store, close;

    always_comb
    begin
        accept     = in_valid && !in_stall;
        live       = accept && rx_enable && (rx_byte != tlf_pkg::CR_BYTE);
        close_term = live && (rx_byte == terminator);
        close_ovf  = live && (rx_byte != terminator) && (pos_reg >= CAPACITY);
        do_store   = live && (rx_byte != terminator) && (pos_reg < CAPACITY);
        close      = close_term || close_ovf;

        pos_next      = pos_reg;
        counter_next  = counter_reg;
        cur_bank_next = cur_bank_reg;
        busy_next     = busy_reg;

        if (release_in.valid)
        begin
            busy_next[release_in.bank] = 1'b0;
        end
        if (do_store)
        begin
            pos_next = pos_reg + 1'b1;
        end
        if (close)
        begin
            pos_next                = '0;
            counter_next            = counter_reg + 16'd1;
            cur_bank_next           = !cur_bank_reg;
            busy_next[cur_bank_reg] = 1'b1;
        end

        store_wr.en   = do_store;
        store_wr.bank = cur_bank_reg;
        store_wr.addr = pos_reg;
        store_wr.data = rx_byte;

        push               = close;
        push_desc.bank     = cur_bank_reg;
        push_desc.len      = close_ovf ? CAPACITY : pos_reg;
        push_desc.ovf      = close_ovf;
        push_desc.ovf_byte = close_ovf ? rx_byte : 8'd0;
        push_desc.number   = counter_reg + 16'd1;
    end

    // The bank being filled must not still hold a frame that is draining.
    assign in_stall = busy_reg[cur_bank_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            counter_reg  <= '0;
            cur_bank_reg <= 1'b0;
            busy_reg     <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            counter_reg  <= counter_next;
            cur_bank_reg <= cur_bank_next;
            busy_reg     <= busy_next;
        end
    end

    a_close_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> busy_reg[$past(cur_bank_reg)])
        else $error("closed bank not marked busy");

    a_release_of_busy: assert property (@(posedge clk) disable iff (!rst_n)
        release_in.valid |-> busy_reg[release_in.bank])
        else $error("release of a bank that holds no frame");

endmodule

/* rtl/tlf_desc_queue.sv */
module tlf_desc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  tlf_pkg::frame_desc_t push_desc,
    input  logic                 pop,
    output logic                 empty,
    output tlf_pkg::frame_desc_t head
);

    localparam int PTR_W = $clog2(tlf_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tlf_pkg::QUEUE_DEPTH + 1);

    tlf_pkg::frame_desc_t entry_reg [tlf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;

    always_comb
    begin
        empty       = (count_reg == '0);
        full        = (count_reg == CNT_W'(tlf_pkg::QUEUE_DEPTH));
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(tlf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(tlf_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                            : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("descriptor queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("descriptor queue underrun");

endmodule

/* rtl/tlf_back.sv */
module tlf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  tlf_pkg::store_wr_t     store_wr,
    input  logic                   q_empty,
    input  tlf_pkg::frame_desc_t   q_head,
    output logic                   pop,
    output tlf_pkg::bank_release_t release_out,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [7:0]             frame_byte,
    output logic                   byte_valid,
    output logic                   last_of_frame,
    output logic [5:0]             frame_length,
    output logic                   overflowed,
    output logic [7:0]             overflow_byte,
    output logic [15:0]            frame_number
);

    // Two line banks side by side; the bank bit is the top address bit.
    logic [7:0] mem [2 * tlf_pkg::BANK_DEPTH];

    logic [tlf_pkg::ADDR_W-1:0] k_reg, k_next;
    logic                       out_valid_reg, out_valid_next;
    logic [7:0]                 rd_data_reg;
    logic                       byte_valid_reg, last_reg, ovf_reg;
    logic [5:0]                 len_reg;
    logic [7:0]                 ovf_byte_reg;
    logic [15:0]                number_reg;

    logic                       advance, load, is_last;
    logic [tlf_pkg::ADDR_W-1:0] last_index;

    always_comb
    begin
        advance    = !out_valid_reg || !out_stall;
        load       = advance && !q_empty;
        last_index = (q_head.len == '0) ? '0 : q_head.len - 1'b1;
        is_last    = (k_reg == last_index);

        out_valid_next = advance ? !q_empty : out_valid_reg;
        k_next         = k_reg;
        if (load)
        begin
            k_next = is_last ? '0 : k_reg + 1'b1;
        end

        pop               = load && is_last;
        release_out.valid = pop;
        release_out.bank  = q_head.bank;
    end

    always_ff @(posedge clk)
    begin
        if (store_wr.en)
        begin
            mem[{store_wr.bank, store_wr.addr}] <= store_wr.data;
        end
        if (load)
        begin
            rd_data_reg    <= mem[{q_head.bank, k_reg}];
            byte_valid_reg <= (q_head.len != '0);
            last_reg       <= is_last;
            len_reg        <= q_head.len;
            ovf_reg        <= q_head.ovf;
            ovf_byte_reg   <= q_head.ovf_byte;
            number_reg     <= q_head.number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_byte    = byte_valid_reg ? rd_data_reg : 8'd0;
    assign byte_valid    = byte_valid_reg;
    assign last_of_frame = last_reg;
    assign frame_length  = len_reg;
    assign overflowed    = ovf_reg;
    assign overflow_byte = ovf_byte_reg;
    assign frame_number  = number_reg;

    a_release_with_last: assert property (@(posedge clk) disable iff (!rst_n)
        release_out.valid |=> out_valid_reg && last_reg)
        else $error("bank released without its last transfer");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> k_reg <= last_index)
        else $error("drain index beyond frame length");

endmodule

/* rtl/terminated_line_framer.sv */
// Channel   Direction  Handshake            Payload
// rx        in         in_valid / in_stall  rx_byte
// frame     out        out_valid/out_stall  frame_byte, byte_valid, last_of_frame,
//                                           frame_length, overflowed, overflow_byte,
//                                           frame_number
// config    in         APB write/read       terminator_char (0x0), receive_enable (0x4)
//
// One received byte is taken per cycle while in_stall is low; the front part writes each data
// byte into one of two line banks. A closed frame is drained at one result per cycle while
// out_stall is low, limited by the single bank read port, through the descriptor queue and
// the output register. in_stall rises only when the front's current bank still holds a frame
// that is draining. Reset clears the control state; the line banks need no clearing pass.
module terminated_line_framer #(
    parameter int LINE_DEPTH = tlf_pkg::LINE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        byte_valid,
    output logic        last_of_frame,
    output logic [5:0]  frame_length,
    output logic        overflowed,
    output logic [7:0]  overflow_byte,
    output logic [15:0] frame_number
);

    logic [7:0] terminator_reg, terminator_next;
    logic       rx_enable_reg, rx_enable_next;
    logic       cfg_write;

    tlf_pkg::store_wr_t     store_wr;
    tlf_pkg::frame_desc_t   push_desc, q_head;
    tlf_pkg::bank_release_t bank_release;
    logic                   push, pop, q_empty;

    assign pready = 1'b1;

    always_comb
    begin
        cfg_write       = psel && penable && pwrite && pready;
        terminator_next = terminator_reg;
        rx_enable_next  = rx_enable_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                tlf_pkg::REG_TERMINATOR: terminator_next = pwdata[7:0];
                tlf_pkg::REG_RX_ENABLE:  rx_enable_next  = pwdata[0];
                default: ;
            endcase
        end
        case (paddr[2])
            tlf_pkg::REG_TERMINATOR: prdata = {24'd0, terminator_reg};
            tlf_pkg::REG_RX_ENABLE:  prdata = {31'd0, rx_enable_reg};
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terminator_reg <= tlf_pkg::TERMINATOR_RESET;
            rx_enable_reg  <= tlf_pkg::RX_ENABLE_RESET;
        end
        else
        begin
            terminator_reg <= terminator_next;
            rx_enable_reg  <= rx_enable_next;
        end
    end

    tlf_front #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .terminator (terminator_reg),
        .rx_enable  (rx_enable_reg),
        .release_in (bank_release),
        .store_wr   (store_wr),
        .push       (push),
        .push_desc  (push_desc)
    );

    tlf_desc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    tlf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .store_wr      (store_wr),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (pop),
        .release_out   (bank_release),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_valid    (byte_valid),
        .last_of_frame (last_of_frame),
        .frame_length  (frame_length),
        .overflowed    (overflowed),
        .overflow_byte (overflow_byte),
        .frame_number  (frame_number)
    );

endmodule

/* tb/sv/terminated_line_framer_tb.sv */
module terminated_line_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = (tlf_pkg::LINE_DEPTH_DEFAULT - 1 > 63) ? 63
                                                               : tlf_pkg::LINE_DEPTH_DEFAULT - 1;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 96;

    typedef struct packed {
        logic [7:0]  fbyte;
        logic        bvalid;
        logic        last;
        logic [5:0]  len;
        logic        ovf;
        logic [7:0]  ovf_byte;
        logic [15:0] number;
    } frame_res_t;

    typedef enum logic [1:0] {ROW_RX, ROW_TERM, ROW_EN} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        typed;
        frame_res_t  want;
    } dir_row_t;

    localparam frame_res_t NO_RES = '0;
    localparam int N_DIR = 23;

    // Rows with a typed result are empty frames; the rest go through the predictor.
    localparam dir_row_t DIRECTED [N_DIR] = '{
        '{ROW_RX,   32'h0000_000A, 1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 1'b0, 8'h00, 16'd1}},
        '{ROW_RX,   32'h0000_000D, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_00FF, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0041, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_000D, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_000A, 1'b0, NO_RES},
        '{ROW_TERM, 32'hFFFF_FF0D, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0055, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_000D, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_000A, 1'b0, NO_RES},
        '{ROW_TERM, 32'h0000_00FF, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_00FF, 1'b0, NO_RES},
        '{ROW_TERM, 32'h0000_0000, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0000, 1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 1'b0, 8'h00, 16'd4}},
        '{ROW_EN,   32'hFFFF_FFFE, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_007E, 1'b0, NO_RES},
        '{ROW_EN,   32'h0000_0001, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0080, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_0000, 1'b0, NO_RES},
        '{ROW_TERM, 32'h0000_000A, 1'b0, NO_RES},
        '{ROW_RX,   32'h0000_000A, 1'b1, '{8'h00, 1'b0, 1'b1, 6'd0, 1'b0, 8'h00, 16'd6}}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  frame_byte;
    logic        byte_valid;
    logic        last_of_frame;
    logic [5:0]  frame_length;
    logic        overflowed;
    logic [7:0]  overflow_byte;
    logic [15:0] frame_number;

    terminated_line_framer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_byte    (frame_byte),
        .byte_valid    (byte_valid),
        .last_of_frame (last_of_frame),
        .frame_length  (frame_length),
        .overflowed    (overflowed),
        .overflow_byte (overflow_byte),
        .frame_number  (frame_number)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Framer state as the testbench sees it.
    logic [7:0]  line_copy [64];
    int          fill_level = 0;
    logic [15:0] frames_closed = '0;
    logic [7:0]  term_char = tlf_pkg::TERMINATOR_RESET;
    logic        rx_on = tlf_pkg::RX_ENABLE_RESET;

    frame_res_t  pending_frames [$];
    frame_res_t  closing_frame [$];
    int          fail_count = 0;
    int          send_idle = 24;
    int          recv_idle = 49;
    bit          hold_req = 1'b0;
    int          hold_left = 0;

    task automatic frame_predict(input logic [7:0] b);
        int         count;
        logic [5:0] len;
        logic       ovf;
        logic [7:0] ovf_b;
        frame_res_t r;
        closing_frame.delete();
        if (!rx_on || b == tlf_pkg::CR_BYTE)
            return;
        if (b == term_char)
        begin
            len = 6'(fill_level);
            ovf = 1'b0;
            ovf_b = 8'h00;
        end
        else if (fill_level >= CAP)
        begin
            len = 6'(CAP);
            ovf = 1'b1;
            ovf_b = b;
        end
        else
        begin
            line_copy[fill_level] = b;
            fill_level++;
            return;
        end
        frames_closed = frames_closed + 16'd1;
        count = (len == 0) ? 1 : int'(len);
        for (int k = 0; k < count; k++)
        begin
            r.fbyte = (len != 0) ? line_copy[k] : 8'h00;
            r.bvalid = (len != 0);
            r.last = (k + 1 == count);
            r.len = len;
            r.ovf = ovf;
            r.ovf_byte = ovf_b;
            r.number = frames_closed;
            closing_frame.push_back(r);
        end
        fill_level = 0;
    endtask

    // One byte transfer; a typed expectation replaces the predicted one.
    task automatic send_byte(input logic [7:0] b, input logic typed, input frame_res_t want);
        @(negedge clk);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        frame_predict(b);
        if (typed)
            pending_frames.push_back(want);
        else
            foreach (closing_frame[i])
                pending_frames.push_back(closing_frame[i]);
    endtask

    task automatic drain_output();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic sel, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == tlf_pkg::REG_TERMINATOR)
            term_char = data[7:0];
        else
            rx_on = data[0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [7:0] data_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while (b == term_char || b == tlf_pkg::CR_BYTE);
        return b;
    endfunction

    task automatic run_phase(input logic [7:0] term);
        int  sent;
        int  pick;
        int  len;
        bit  ovf_done;
        sent = 0;
        ovf_done = 1'b0;
        drain_output();
        reg_write(tlf_pkg::REG_TERMINATOR, {$urandom_range(255) << 8} | 32'(term));
        reg_write(tlf_pkg::REG_RX_ENABLE, ($urandom() & 32'hFFFF_FFFE) | 32'd1);
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(99);
            if (!ovf_done && (pick < 8 || sent > PHASE_ITEMS / 2))
            begin
                // A full line and one more data byte closes the frame as an overflow.
                for (int i = 0; i <= CAP; i++)
                    send_byte(data_byte(), 1'b0, NO_RES);
                sent += CAP + 1;
                ovf_done = 1'b1;
            end
            else if (pick < 18)
            begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(255)), 1'b0, NO_RES);
                sent += len;
            end
            else
            begin
                len = (pick < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(9) == 0)
                        send_byte(tlf_pkg::CR_BYTE, 1'b0, NO_RES);
                    send_byte(data_byte(), 1'b0, NO_RES);
                end
                send_byte(term_char, 1'b0, NO_RES);
                sent += len + 1;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    always @(posedge clk)
    begin
        frame_res_t got;
        frame_res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {frame_byte, byte_valid, last_of_frame, frame_length,
                   overflowed, overflow_byte, frame_number};
            if (pending_frames.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: byte %h valid %b last %b len %0d ovf %b/%h num %0d",
                             got.fbyte, got.bvalid, got.last, got.len,
                             got.ovf, got.ovf_byte, got.number);
            end
            else
            begin
                want = pending_frames.pop_front();
                if (got.fbyte !== want.fbyte || got.bvalid !== want.bvalid
                    || got.last !== want.last || got.len !== want.len
                    || got.ovf !== want.ovf || got.ovf_byte !== want.ovf_byte
                    || got.number !== want.number)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("want: byte %h valid %b last %b len %0d ovf %b/%h num %0d",
                                 want.fbyte, want.bvalid, want.last, want.len,
                                 want.ovf, want.ovf_byte, want.number);
                        $display("got:  byte %h valid %b last %b len %0d ovf %b/%h num %0d",
                                 got.fbyte, got.bvalid, got.last, got.len,
                                 got.ovf, got.ovf_byte, got.number);
                    end
                end
            end
        end
    end

    initial
    begin
        logic [7:0] term;
        foreach (line_copy[i])
            line_copy[i] = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
        begin
            if (DIRECTED[i].kind == ROW_RX)
                send_byte(DIRECTED[i].value[7:0], DIRECTED[i].typed, DIRECTED[i].want);
            else
            begin
                drain_output();
                reg_write((DIRECTED[i].kind == ROW_TERM) ? tlf_pkg::REG_TERMINATOR
                                                         : tlf_pkg::REG_RX_ENABLE,
                          DIRECTED[i].value);
            end
        end

        run_phase(8'h0A);

        send_idle = 49;
        recv_idle = 24;
        run_phase(8'hFF);

        send_idle = 0;
        recv_idle = 0;
        do
            term = 8'($urandom_range(255));
        while (term == tlf_pkg::CR_BYTE);
        // The receiver holds off for a while so that both line banks fill and
        // the input transfer stalls.
        drain_output();
        hold_req = 1'b1;
        run_phase(term);

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_frames.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
